/* rtl/pre_pkg.sv */
// Package for the page replacement engine: payload structs, policy codes, constants.
// No dependencies.
package pre_pkg;
	localparam int MaxFrames = 8;
	localparam int PageBits = 8;
	localparam int FreqBits = 16;
	localparam int TotBits = 16;

	typedef enum logic [1:0] {
		POL_FIFO = 2'd0,
		POL_LRU  = 2'd1,
		POL_LFU  = 2'd2,
		POL_LFU3 = 2'd3
	} policy_t;

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [0:0] REG_POLICY = 1'b0;
	localparam logic [0:0] REG_FRAMES = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] page_number;
	} in_word_t;

	typedef struct packed {
		logic        hit;
		logic        fault;
		logic        replaced;
		logic [2:0]  frame_index;
		logic [7:0]  evicted_page;
		logic [15:0] fault_total;
		logic [15:0] hit_total;
	} out_word_t;
endpackage

/* rtl/pre_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pre_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/page_replacement_engine_unit.sv */
// Top level of the page replacement engine: frame table, sequencer, frequency memory.
// Depends on pre_pkg and pre_ram.
//
//  channel | direction | handshake           | word
//  in      | input     | in_valid/in_stall   | in_word_t  (command, page_number)
//  out     | output    | out_valid/out_stall | out_word_t (hit ... hit_total)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// In an access, S_RD issues the count read, S_WB writes the count back and
// picks the path, S_DONE loads the result register; the next word is taken back in S_IDLE.
// An LFU or LFU3 fault with every active frame full adds a read (S_LOOK) and a compare
// (S_SCAN) per active frame; the single frequency read port sets this.
// A clear answers at once, then sweeps all 2^PAGE_BITS words of the frequency memory
// in S_CLR with the input stalled; reset runs the same sweep.
// The result sits in an output register; a stalled output holds S_DONE and the input.
module page_replacement_engine_unit
	import pre_pkg::*;
#(
	parameter int MAX_FRAMES = MaxFrames,
	parameter int PAGE_BITS = PageBits
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [3:0] cfg_data
);
	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int PC = 1 << PAGE_BITS;
	localparam int NW = $clog2(MAX_FRAMES + 1);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_RD, S_WB, S_LOOK, S_SCAN, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] policy_q;
	logic [3:0] frames_q;
	logic [PAGE_BITS-1:0] page_q, clr_q;
	logic [PAGE_BITS-1:0] fpage_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] fvalid_q;
	logic [FW-1:0] rrank_q [MAX_FRAMES];
	logic [FW-1:0] lrank_q [MAX_FRAMES];
	logic [TotBits-1:0] faults_q, hits_q;
	logic [FW-1:0] scan_q, best_q;
	logic [FreqBits-1:0] bestf_q;
	logic scan_first_q;

	// frequency memory
	logic ram_we;
	logic [PAGE_BITS-1:0] ram_waddr, ram_raddr;
	logic [FreqBits-1:0] ram_wdata, ram_rdata;

	pre_ram #(.Width(FreqBits), .Depth(PC)) u_freq (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// active frame count
	logic [NW-1:0] n_act;
	always_comb begin
		if (frames_q == 4'd0) n_act = NW'(1);
		else if (32'(frames_q) > MAX_FRAMES) n_act = NW'(MAX_FRAMES);
		else n_act = NW'(frames_q);
	end

	// lookup of page and first empty frame
	logic hit_c, empty_c;
	logic [FW-1:0] hitf_c, empf_c, vict_c;
	always_comb begin
		hit_c = 1'b0; empty_c = 1'b0; hitf_c = '0; empf_c = '0;
		for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
			if (j < 32'(n_act)) begin
				if (fvalid_q[j] && fpage_q[j] == page_q) begin
					hit_c = 1'b1; hitf_c = FW'(j);
				end
				if (!fvalid_q[j]) begin
					empty_c = 1'b1; empf_c = FW'(j);
				end
			end
		end
		// FIFO / LRU victim: greatest rank, lowest index on ties
		vict_c = '0;
		for (int j = 1; j < MAX_FRAMES; j++) begin
			if (j < 32'(n_act)) begin
				if (policy_q == POL_FIFO) begin
					if (lrank_q[j] > lrank_q[vict_c]) vict_c = FW'(j);
				end else begin
					if (rrank_q[j] > rrank_q[vict_c]) vict_c = FW'(j);
				end
			end
		end
	end

	// frequency read address: page during access, scanned frame's page in LFU scan
	always_comb begin
		ram_raddr = page_q;
		if (state_q == S_LOOK || state_q == S_SCAN) ram_raddr = fpage_q[scan_q];
	end

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);

	logic is_lfu;
	assign is_lfu = policy_q[1];

	// count read in S_RD lands in S_WB, written back incremented (saturating)
	always_comb begin
		ram_we = 1'b0; ram_waddr = clr_q; ram_wdata = '0;
		if (state_q == S_CLR) ram_we = 1'b1;
		else if (state_q == S_WB) begin
			ram_we = (ram_rdata != '1);
			ram_waddr = page_q;
			ram_wdata = ram_rdata + 1'b1;
		end
	end

	// the LFU scan only runs on a fault, so the accessed page is never among the
	// scanned frames and its fresh count needs no forwarding
	logic [FreqBits-1:0] scan_f;
	assign scan_f = ram_rdata;

	logic [FW-1:0] fin_f;
	logic fin_hit, fin_rep;

	// final choice of frame
	always_comb begin
		fin_hit = hit_c;
		fin_rep = !hit_c && !empty_c;
		if (hit_c) fin_f = hitf_c;
		else if (empty_c) fin_f = empf_c;
		else if (is_lfu) fin_f = best_q;
		else fin_f = vict_c;
	end

	// rank step conditions: empty fill uses old = n (all valid below n move)
	function automatic logic fin_rep_or_empty_r(input int j);
		logic r;
		begin
			r = (!fin_hit && !fin_rep) ? 1'b1
			    : ({1'b0, rrank_q[j]} < {1'b0, rrank_q[fin_f]});
			return r;
		end
	endfunction

	function automatic logic lrank_old_lt(input int j);
		logic r;
		begin
			r = (!fin_rep) ? 1'b1 : (lrank_q[j] < lrank_q[fin_f]);
			return r;
		end
	endfunction

	// result word: clear answers at once with zeros, an access from S_DONE
	logic out_load;
	out_word_t res_c;
	always_comb begin
		out_load = 1'b0;
		res_c = '0;
		if (state_q == S_IDLE) begin
			out_load = in_valid && !in_stall && (in_word.command == CMD_CLEAR);
		end else if (state_q == S_DONE && !(out_valid && out_stall)) begin
			out_load = 1'b1;
			res_c.hit = fin_hit;
			res_c.fault = !fin_hit;
			res_c.replaced = fin_rep;
			res_c.frame_index = 3'(fin_f);
			res_c.evicted_page = fin_rep ? 8'(fpage_q[fin_f]) : 8'd0;
			res_c.fault_total = (!fin_hit && faults_q != '1) ? faults_q + 1'b1 : faults_q;
			res_c.hit_total = (fin_hit && hits_q != '1) ? hits_q + 1'b1 : hits_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			policy_q <= 2'd0;
			frames_q <= 4'd3;
			fvalid_q <= '0;
			faults_q <= '0;
			hits_q <= '0;
			out_valid <= 1'b0;
			out_word <= '0;
			page_q <= '0;
			scan_q <= '0;
			best_q <= '0;
			bestf_q <= '0;
			scan_first_q <= 1'b0;
			for (int j = 0; j < MAX_FRAMES; j++) begin
				fpage_q[j] <= '0; rrank_q[j] <= '0; lrank_q[j] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POLICY) policy_q <= cfg_data[1:0];
				else frames_q <= cfg_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
				out_word <= res_c;
			end else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						if (in_word.command == CMD_CLEAR) begin
							fvalid_q <= '0;
							faults_q <= '0;
							hits_q <= '0;
							for (int j = 0; j < MAX_FRAMES; j++) begin
								fpage_q[j] <= '0; rrank_q[j] <= '0; lrank_q[j] <= '0;
							end
							clr_q <= '0;
							state_q <= S_CLR;
						end else begin
							page_q <= PAGE_BITS'(in_word.page_number);
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					// count read of page_q issued; data next cycle
					state_q <= S_WB;
				end
				S_WB: begin
					// count write happens here; decide path
					scan_q <= '0;
					scan_first_q <= 1'b1;
					if (!hit_c && !empty_c && is_lfu) state_q <= S_LOOK;
					else state_q <= S_DONE;
				end
				S_LOOK: begin
					// read of frame scan_q issued; data next cycle
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_first_q || scan_f < bestf_q ||
					    (scan_f == bestf_q && lrank_q[scan_q] > lrank_q[best_q])) begin
						best_q <= scan_q;
						bestf_q <= scan_f;
					end
					scan_first_q <= 1'b0;
					if (32'(scan_q) + 1 >= 32'(n_act)) state_q <= S_DONE;
					else begin
						scan_q <= scan_q + 1'b1;
						state_q <= S_LOOK;
					end
				end
				S_DONE: begin
					if (!(out_valid && out_stall)) begin
						if (fin_hit) begin
							if (hits_q != '1) hits_q <= hits_q + 1'b1;
						end else begin
							if (faults_q != '1) faults_q <= faults_q + 1'b1;
							fpage_q[fin_f] <= page_q;
							fvalid_q[fin_f] <= 1'b1;
						end
						for (int j = 0; j < MAX_FRAMES; j++) begin
							if (j < 32'(n_act)) begin
								if (FW'(j) == fin_f) rrank_q[j] <= '0;
								else if (fvalid_q[j] && (fin_rep_or_empty_r(j)))
									rrank_q[j] <= rrank_q[j] + 1'b1;
								if (!fin_hit) begin
									if (FW'(j) == fin_f) lrank_q[j] <= '0;
									else if (fvalid_q[j] && lrank_old_lt(j))
										lrank_q[j] <= lrank_q[j] + 1'b1;
								end
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_one_hot_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.hit && out_word.fault)) else $error("hit and fault");
	a_replace_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.replaced |-> out_word.fault) else $error("replace without fault");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
`endif
endmodule
